// ----- rtl/core/dqlt_pkg.sv -----
package dqlt_pkg;

    localparam int ADDR_W  = 32;
    localparam int IDENT_W = 16;
    localparam int TIME_W  = 32;
    localparam int SUM_W   = 48;

    // One pending query as it lies in the table memory.
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  addr_low;
        logic [ADDR_W-1:0]  addr_high;
        logic [IDENT_W-1:0] ident;
        logic [TIME_W-1:0]  stamp;
    } entry_t;

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_UPDATE = 6'b001000,
        ST_DIVIDE = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    localparam logic KIND_QUERY    = 1'b0;
    localparam logic KIND_RESPONSE = 1'b1;

endpackage

// ----- rtl/core/dns_query_latency_tracker_core.sv -----
// Channel  | Direction | tdata (low bit up)                             | tuser
// s_       | in        | src_ip, dst_ip, query_id, timestamp_ms         | kind
// m_       | out       | latency_ms, average_ms, worst_ms, answered_count | matched, dropped
//
// A transaction is taken in the idle state. Its result passes through the lookup scan (one
// memory read per entry and a compare of the registered read data), a write-back state, the
// 48 steps of the serial divider, and the load of the output register once that register is
// free. The next transaction is taken when the state machine has returned to idle.
// After reset a clearing pass writes every table entry invalid first.
// A held result does not block the next transaction until that one's result is ready.
module dns_query_latency_tracker_core #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [111:0] s_tdata,   // src_ip, dst_ip, query_id, timestamp_ms
    input  logic [0:0]   s_tuser,   // kind
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // latency_ms, average_ms, worst_ms, answered_count
    output logic [1:0]   m_tuser    // matched, dropped
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam logic [IW:0] LAST_CNT = (IW+1)'(TABLE_ENTRIES);
    localparam int DIV_STEPS = dqlt_pkg::SUM_W;
    localparam int DW = $clog2(DIV_STEPS + 1);

    // Table memory with registered read.
    dqlt_pkg::entry_t mem [TABLE_ENTRIES];
    dqlt_pkg::entry_t rd_data_reg;
    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    dqlt_pkg::entry_t wr_data;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    dqlt_pkg::state_t state_reg, state_next;
    logic [IW:0]  cnt_reg, cnt_next;
    logic         cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0] cmp_idx_reg, cmp_idx_next;

    // Captured transaction.
    logic        kind_reg, kind_next;
    logic [31:0] lo_reg, lo_next, hi_reg, hi_next, now_reg, now_next;
    logic [15:0] id_reg, id_next;

    // Scan results.
    logic          hit_reg, hit_next, free_reg, free_next;
    logic [IW-1:0] hit_idx_reg, hit_idx_next, free_idx_reg, free_idx_next;
    logic [31:0]   hit_time_reg, hit_time_next;

    // Statistics.
    logic [47:0] sum_reg, sum_next;
    logic [31:0] worst_reg, worst_next, count_reg, count_next;
    logic        matched_reg, matched_next, dropped_reg, dropped_next;
    logic [31:0] lat_reg, lat_next;

    // Serial divider.
    logic [47:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [DW-1:0] step_reg, step_next;
    logic [32:0] rem_shift;

    // Output register.
    logic         m_vld_reg, m_vld_next;
    logic [127:0] m_data_reg, m_data_next;
    logic [1:0]   m_user_reg, m_user_next;

    logic [32:0] lat_full;
    logic [48:0] sum_full;
    logic [31:0] lat_new;
    logic [31:0] avg;

    assign s_tready = (state_reg == dqlt_pkg::ST_IDLE);
    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        kind_next     = kind_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        now_next      = now_reg;
        id_next       = id_reg;
        hit_next      = hit_reg;
        free_next     = free_reg;
        hit_idx_next  = hit_idx_reg;
        free_idx_next = free_idx_reg;
        hit_time_next = hit_time_reg;
        sum_next      = sum_reg;
        worst_next    = worst_reg;
        count_next    = count_reg;
        matched_next  = matched_reg;
        dropped_next  = dropped_reg;
        lat_next      = lat_reg;
        quo_next      = quo_reg;
        rem_next      = rem_reg;
        step_next     = step_reg;
        m_vld_next    = m_vld_reg;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        rd_addr       = cnt_reg[IW-1:0];
        wr_en         = 1'b0;
        wr_addr       = cnt_reg[IW-1:0];
        wr_data       = '0;
        lat_full      = {1'b0, now_reg} - {1'b0, hit_time_reg};
        lat_new       = lat_full[31:0];
        sum_full      = {1'b0, sum_reg} + {17'd0, lat_new};
        rem_shift     = {rem_reg, quo_reg[47]};
        avg           = (quo_reg[47:32] != '0) ? 32'hFFFF_FFFF : quo_reg[31:0];

        // A finished result leaves the output register.
        if (m_vld_reg && m_tready) begin
            m_vld_next = 1'b0;
        end

        unique case (state_reg)
            dqlt_pkg::ST_CLEAR: begin
                // Write every entry invalid after reset.
                wr_en    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT - 1'b1) begin
                    state_next = dqlt_pkg::ST_IDLE;
                end
            end
            dqlt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next = s_tuser[0];
                    if (s_tdata[31:0] < s_tdata[63:32]) begin
                        lo_next = s_tdata[31:0];
                        hi_next = s_tdata[63:32];
                    end else begin
                        lo_next = s_tdata[63:32];
                        hi_next = s_tdata[31:0];
                    end
                    id_next    = s_tdata[79:64];
                    now_next   = s_tdata[111:80];
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    cnt_next   = '0;
                    state_next = dqlt_pkg::ST_SCAN;
                end
            end
            dqlt_pkg::ST_SCAN: begin
                // Issue one read per cycle; compare the data read in the cycle before.
                if (cnt_reg != LAST_CNT) begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = cnt_reg[IW-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
                if (cmp_vld_reg) begin
                    if (rd_data_reg.valid && !hit_reg && rd_data_reg.addr_low == lo_reg &&
                        rd_data_reg.addr_high == hi_reg && rd_data_reg.ident == id_reg) begin
                        hit_next      = 1'b1;
                        hit_idx_next  = cmp_idx_reg;
                        hit_time_next = rd_data_reg.stamp;
                    end
                    if (!rd_data_reg.valid && !free_reg) begin
                        free_next     = 1'b1;
                        free_idx_next = cmp_idx_reg;
                    end
                end else if (cnt_reg == LAST_CNT) begin
                    state_next = dqlt_pkg::ST_UPDATE;
                end
            end
            dqlt_pkg::ST_UPDATE: begin
                // Write back the table and fold a match into the statistics.
                matched_next = 1'b0;
                dropped_next = 1'b0;
                lat_next     = '0;
                if (kind_reg == dqlt_pkg::KIND_QUERY) begin
                    if (!hit_reg) begin
                        if (free_reg) begin
                            wr_en   = 1'b1;
                            wr_addr = free_idx_reg;
                            wr_data = '{valid: 1'b1, addr_low: lo_reg, addr_high: hi_reg,
                                        ident: id_reg, stamp: now_reg};
                        end else begin
                            dropped_next = 1'b1;
                        end
                    end
                end else if (hit_reg) begin
                    wr_en        = 1'b1;
                    wr_addr      = hit_idx_reg;
                    matched_next = 1'b1;
                    lat_next     = lat_new;
                    sum_next     = sum_full[48] ? 48'hFFFF_FFFF_FFFF : sum_full[47:0];
                    if (count_reg != 32'hFFFF_FFFF) begin
                        count_next = count_reg + 1'b1;
                    end
                    if (lat_new > worst_reg) begin
                        worst_next = lat_new;
                    end
                end
                quo_next   = sum_next;
                rem_next   = '0;
                step_next  = '0;
                state_next = dqlt_pkg::ST_DIVIDE;
            end
            dqlt_pkg::ST_DIVIDE: begin
                // Restoring division, one quotient bit per cycle.
                if (step_reg == DW'(DIV_STEPS)) begin
                    state_next = dqlt_pkg::ST_DONE;
                end else begin
                    step_next = step_reg + 1'b1;
                    if (rem_shift >= {1'b0, count_reg}) begin
                        rem_next = 32'(rem_shift - {1'b0, count_reg});
                        quo_next = {quo_reg[46:0], 1'b1};
                    end else begin
                        rem_next = rem_shift[31:0];
                        quo_next = {quo_reg[46:0], 1'b0};
                    end
                end
            end
            dqlt_pkg::ST_DONE: begin
                // Load the result once the output register is free.
                if (!m_vld_next) begin
                    m_vld_next  = 1'b1;
                    m_user_next = {dropped_reg, matched_reg};
                    if (count_reg == '0) begin
                        m_data_next = {count_reg, 32'd0, 32'd0, lat_reg};
                    end else begin
                        m_data_next = {count_reg, worst_reg, avg, lat_reg};
                    end
                    state_next = dqlt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = dqlt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dqlt_pkg::ST_CLEAR;
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            sum_reg     <= '0;
            worst_reg   <= '0;
            count_reg   <= '0;
            m_vld_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cmp_vld_reg <= cmp_vld_next;
            sum_reg     <= sum_next;
            worst_reg   <= worst_next;
            count_reg   <= count_next;
            m_vld_reg   <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg  <= cmp_idx_next;
        kind_reg     <= kind_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        now_reg      <= now_next;
        id_reg       <= id_next;
        hit_reg      <= hit_next;
        free_reg     <= free_next;
        hit_idx_reg  <= hit_idx_next;
        free_idx_reg <= free_idx_next;
        hit_time_reg <= hit_time_next;
        matched_reg  <= matched_next;
        dropped_reg  <= dropped_next;
        lat_reg      <= lat_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        step_reg     <= step_next;
        m_data_reg   <= m_data_next;
        m_user_reg   <= m_user_next;
    end

    // A result never reports both a match and a drop.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("result both matched and dropped");

    // Latency is zero unless the response matched.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == '0))
        else $error("latency without a match");

    // A matched result always carries a nonzero answered count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[127:96] != '0))
        else $error("match with zero count");

endmodule
